/* sv/assert_macros.svh */
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define FLF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check on every rising edge, reset included.
`define FLF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/flf_pkg.sv */
`default_nettype none

package flf_pkg;

    localparam int COEF_W = 21;
    localparam int CTRL_W = 16;
    localparam int MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_ZERO       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOWPASS    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HIGHPASS   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BANDPASS   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BANDREJECT = 3'd4;

    // Q.16 constants
    localparam logic [19:0] K_0P8   = 20'd52429;
    localparam logic [19:0] K_0P89  = 20'd58327;
    localparam logic [19:0] K_5P6   = 20'd367002;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef logic signed [COEF_W-1:0] coef_t;

endpackage

`default_nettype wire

/* sv/flf_sermul.sv */
`default_nettype none

// Radix-2 shift-add multiplier: one multiplier bit per cycle, sign bit last.
module flf_sermul import flf_pkg::*; #(
    parameter int MCAND_W = 34,
    localparam int PROD_W = MCAND_W + COEF_W
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [MCAND_W-1:0] mcand,
    input  coef_t                    mplier,
    output logic                     done,
    output logic signed [PROD_W-1:0] prod
);

    localparam int CNT_W = $clog2(COEF_W + 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [PROD_W-1:0] mc_reg;
    logic [COEF_W-1:0]        mp_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] acc_next;
    logic signed [PROD_W-1:0] addend;
    logic                     last;

    always_comb begin
        addend   = mp_reg[0] ? mc_reg : '0;
        last     = (cnt_reg == CNT_W'(COEF_W - 1));
        // sign bit of the multiplier weighs negative
        acc_next = last ? (acc_reg - addend) : (acc_reg + addend);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mc_reg  <= PROD_W'(mcand);
            mp_reg  <= mplier;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            mc_reg  <= mc_reg <<< 1;
            mp_reg  <= mp_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

/* sv/four_pole_ladder_filter_unit.sv */
`default_nettype none

// Channel   Direction  Fields (low bit up)
// s_        in         sample_in, cutoff, resonance
// m_        out        sample_out
// cfg_      in         output_mode
//
// One sample takes 16 multiplies on one shift-add multiplier, each one issued,
// stepped through its 21 bit steps and collected, plus the handshake; the
// multiplier works one multiplier bit per cycle.
// A new request is taken only once the last result is in the output register.
// aresetn (synchronous, active low) clears the filter state and sets lowpass.
// A result waits in the output register while the next request is taken;
// a new result is held back only until the old one is taken.
module four_pole_ladder_filter_unit import flf_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 32,
    localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 2 * CTRL_W + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [MODE_W-1:0]      cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample_in, cutoff, resonance
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // sample_out
);

    localparam int SW     = STATE_WIDTH;
    localparam int MC_W   = SW + 2;
    localparam int PROD_W = MC_W + COEF_W;
    localparam int RND_W  = PROD_W - 16;
    localparam int Y_W    = SW + 9;
    localparam int SHIFT  = (SW - 5) - (SAMPLE_WIDTH - 1);
    localparam int SH_POS = (SHIFT > 0) ? SHIFT : 0;
    localparam int SH_NEG = (SHIFT < 0) ? -SHIFT : 0;
    localparam longint RND_ADD = (SH_POS > 0) ? (64'sd1 <<< (SH_POS - 1)) : 64'sd0;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [3:0] STEP_A1    = 4'd0;
    localparam logic [3:0] STEP_P     = 4'd1;
    localparam logic [3:0] STEP_Q2    = 4'd2;
    localparam logic [3:0] STEP_INNER = 4'd3;
    localparam logic [3:0] STEP_OUTER = 4'd4;
    localparam logic [3:0] STEP_RO    = 4'd5;
    localparam logic [3:0] STEP_FB    = 4'd6;
    localparam logic [3:0] STEP_X     = 4'd7;
    localparam logic [3:0] STEP_LAST  = 4'd15;

    logic [1:0]                     state_reg;
    logic [3:0]                     step_reg;
    logic [MODE_W-1:0]              mode_reg;
    logic signed [SAMPLE_WIDTH-1:0] smp_reg;
    logic [CTRL_W-1:0]              cut_reg;
    logic [CTRL_W-1:0]              res_reg;
    logic [19:0]                    tmp_reg;
    logic [17:0]                    p_reg;
    coef_t                          fc_reg;
    logic [17:0]                    fb_reg;
    logic signed [SW-1:0]           x_reg;
    logic signed [SW-1:0]           prev_reg;
    logic signed [SW-1:0]           s1_reg;
    logic signed [SW-1:0]           s2_reg;
    logic signed [SW-1:0]           s3_reg;
    logic signed [SW-1:0]           s4_reg;
    logic signed [SW-1:0]           old_reg;
    logic signed [RND_W-1:0]        t_reg;
    logic [SAMPLE_WIDTH-1:0]        out_reg;
    logic                           m_tvalid_reg;

    logic [16:0]                    q;
    logic [1:0]                     stage_idx;
    logic signed [SW-1:0]           s_cur;
    logic signed [SW-1:0]           s_up_new;
    logic signed [SW-1:0]           s_up_old;
    logic signed [MC_W-1:0]         mc;
    coef_t                          mp;
    logic                           mul_start;
    logic                           mul_done;
    logic signed [PROD_W-1:0]       prod;
    logic signed [PROD_W-1:0]       prod_half;
    logic [PROD_W-1:0]              prod_o17;
    logic signed [RND_W-1:0]        rnd;
    logic signed [RND_W-1:0]        xs;
    logic signed [SW-1:0]           x_next;
    logic signed [SW-1:0]           stage_next;
    logic [17:0]                    p_next;
    logic signed [Y_W-1:0]          d3;
    logic signed [Y_W-1:0]          tri3;
    logic signed [Y_W-1:0]          y;
    logic signed [Y_W-1:0]          y_scaled;
    logic [SAMPLE_WIDTH-1:0]        out_next;
    logic                           out_load;

    function automatic logic signed [SW-1:0] sat_state(input logic signed [RND_W-1:0] v);
        logic [RND_W-SW:0] hi;
        hi = v[RND_W-1:SW-1];
        if (hi == '0 || hi == '1) begin
            return v[SW-1:0];
        end else if (v[RND_W-1]) begin
            return {1'b1, {(SW-1){1'b0}}};
        end else begin
            return {1'b0, {(SW-1){1'b1}}};
        end
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] sat_sample(input logic signed [Y_W-1:0] v);
        logic [Y_W-SAMPLE_WIDTH:0] hi;
        hi = v[Y_W-1:SAMPLE_WIDTH-1];
        if (hi == '0 || hi == '1) begin
            return v[SAMPLE_WIDTH-1:0];
        end else if (v[Y_W-1]) begin
            return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    endfunction

    // q = 1 - cutoff in Q.16
    assign q         = ONE_Q16 - {1'b0, cut_reg};
    assign stage_idx = step_reg[2:1];

    // pick the stage being worked on and what drives it
    always_comb begin
        unique case (stage_idx)
            2'd0: begin
                s_cur    = s1_reg;
                s_up_new = x_reg;
                s_up_old = prev_reg;
            end
            2'd1: begin
                s_cur    = s2_reg;
                s_up_new = s1_reg;
                s_up_old = old_reg;
            end
            2'd2: begin
                s_cur    = s3_reg;
                s_up_new = s2_reg;
                s_up_old = old_reg;
            end
            default: begin
                s_cur    = s4_reg;
                s_up_new = s3_reg;
                s_up_old = old_reg;
            end
        endcase
    end

    // multiplier operands for each step
    always_comb begin
        unique case (step_reg)
            STEP_A1: begin
                mc = $signed(MC_W'(cut_reg));
                mp = $signed(COEF_W'(q));
            end
            STEP_P: begin
                mc = $signed(MC_W'(tmp_reg));
                mp = $signed(COEF_W'(K_0P8));
            end
            STEP_Q2: begin
                mc = $signed(MC_W'(q));
                mp = $signed(COEF_W'(q));
            end
            STEP_INNER: begin
                mc = $signed(MC_W'(tmp_reg));
                mp = $signed(COEF_W'(K_5P6));
            end
            STEP_OUTER: begin
                mc = $signed(MC_W'(tmp_reg));
                mp = $signed(COEF_W'(q));
            end
            STEP_RO: begin
                mc = $signed(MC_W'(res_reg));
                mp = $signed(COEF_W'(tmp_reg));
            end
            STEP_FB: begin
                mc = $signed(MC_W'(tmp_reg));
                mp = $signed(COEF_W'(K_0P89));
            end
            STEP_X: begin
                mc = MC_W'(s4_reg);
                mp = $signed(COEF_W'(fb_reg));
            end
            default: begin
                if (step_reg[0]) begin
                    // stage feedback: stage * fc
                    mc = MC_W'(s_cur);
                    mp = fc_reg;
                end else begin
                    // stage drive: (new + old upstream) * p
                    mc = MC_W'(s_up_new) + MC_W'(s_up_old);
                    mp = $signed(COEF_W'(p_reg));
                end
            end
        endcase
    end

    flf_sermul #(
        .MCAND_W (MC_W)
    ) u_sermul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mc),
        .mplier  (mp),
        .done    (mul_done),
        .prod    (prod)
    );

    assign mul_start = (state_reg == ST_ISSUE);

    // rounding of products and the saturating updates
    always_comb begin
        prod_half  = prod + PROD_W'(32768);
        prod_o17   = prod + PROD_W'(65536);
        rnd        = prod_half[PROD_W-1:16];
        xs         = (RND_W'(smp_reg) <<< SH_POS) >>> SH_NEG;
        x_next     = sat_state(xs - rnd);
        stage_next = sat_state(t_reg - rnd);
        p_next     = 18'(cut_reg) + rnd[17:0];
    end

    // selected response, rounded to sample format
    always_comb begin
        d3   = Y_W'(s3_reg) - Y_W'(s4_reg);
        tri3 = d3 + (d3 <<< 1);
        unique case (mode_reg)
            MODE_LOWPASS:    y = Y_W'(s4_reg);
            MODE_HIGHPASS:   y = Y_W'(x_reg) - Y_W'(s4_reg);
            MODE_BANDPASS:   y = tri3;
            MODE_BANDREJECT: y = tri3 - Y_W'(x_reg);
            default:         y = '0;
        endcase
        y_scaled = ((y + Y_W'(RND_ADD)) >>> SH_POS) <<< SH_NEG;
        out_next = sat_sample(y_scaled);
    end

    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            mode_reg     <= MODE_LOWPASS;
            m_tvalid_reg <= 1'b0;
            prev_reg     <= '0;
            s1_reg       <= '0;
            s2_reg       <= '0;
            s3_reg       <= '0;
            s4_reg       <= '0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            // a fresh result replaces the one being taken in the same cycle
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        step_reg  <= STEP_A1;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (mul_done) begin
                        if (step_reg[3] && step_reg[0]) begin
                            unique case (stage_idx)
                                2'd0:    s1_reg <= stage_next;
                                2'd1:    s2_reg <= stage_next;
                                2'd2:    s3_reg <= stage_next;
                                default: s4_reg <= stage_next;
                            endcase
                        end
                        if (step_reg == STEP_LAST) begin
                            state_reg <= ST_DONE;
                        end else begin
                            step_reg  <= step_reg + 1'b1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                default: begin
                    if (out_load) begin
                        prev_reg  <= x_reg;
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            smp_reg <= $signed(s_tdata[SAMPLE_WIDTH-1:0]);
            cut_reg <= s_tdata[SAMPLE_WIDTH +: CTRL_W];
            res_reg <= s_tdata[SAMPLE_WIDTH + CTRL_W +: CTRL_W];
        end
        if (out_load) begin
            out_reg <= out_next;
        end
        if (state_reg == ST_WAIT && mul_done) begin
            unique case (step_reg)
                STEP_A1:    tmp_reg <= rnd[19:0];
                STEP_P: begin
                    p_reg  <= p_next;
                    fc_reg <= $signed(COEF_W'({p_next, 1'b0})) - $signed(COEF_W'(ONE_Q16));
                end
                STEP_Q2:    tmp_reg <= rnd[19:0];
                STEP_INNER: tmp_reg <= 20'(cut_reg) + rnd[19:0];
                STEP_OUTER: tmp_reg <= 20'(ONE_Q16) + prod_o17[17 +: 20];
                STEP_RO:    tmp_reg <= rnd[19:0];
                STEP_FB:    fb_reg  <= rnd[17:0];
                STEP_X:     x_reg   <= x_next;
                default: begin
                    if (step_reg[0]) begin
                        // hold the old value for the next stage's drive
                        old_reg <= s_cur;
                    end else begin
                        t_reg <= rnd;
                    end
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_reg);

endmodule

`default_nettype wire

/* sv/flf_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module flf_checker #(
    parameter int DATA_W = 16
) (
    input wire              aclk,
    input wire              aresetn,
    input wire              s_tvalid,
    input wire              s_tready,
    input wire              m_tvalid,
    input wire              m_tready,
    input wire [DATA_W-1:0] m_tdata
);

    // reset leaves no result pending and the input open
    `FLF_ASSERT_ALWAYS(a_reset_clean, aclk, !aresetn |=> !m_tvalid && s_tready, "reset state wrong")

    // a taken request keeps the input closed while it is worked on
    `FLF_ASSERT(a_busy_after_req, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "request overlap")

    `FLF_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped")

    `FLF_ASSERT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed")

endmodule

bind four_pole_ladder_filter_unit flf_checker #(.DATA_W(OUT_TDATA_W)) u_flf_checker (.*);

`default_nettype wire
